FILE: rtl/core/mgm_pkg.sv
// mixer package: payload structs, command codes, gain entry layout
// no dependencies
package mgm_pkg;

  localparam int OBJECTS      = 16;
  localparam int OUT_CHANNELS = 16;
  localparam int ENTRY_AW     = 8;
  localparam int ENTRIES      = 256;
  localparam int GAIN_W       = 24;
  localparam int REM_W        = 16;
  localparam int ACC_W        = 48;
  localparam int SIB_W        = 5;
  localparam int SNAP_UNITS   = 420;
  localparam logic [3:0] LFE_CHANNEL = 4'd3;

  localparam logic [1:0] CMD_SET_GAIN = 2'd0;
  localparam logic [1:0] CMD_SET_MAP  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_LFE    = 1'b1;

  localparam logic [1:0] OP_GAIN   = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         object;
    logic [3:0]         channel;
    logic signed [23:0] target_gain;
    logic [19:0]        ramp_duration;
    logic [3:0]         standard_index;
    logic signed [23:0] sample;
    logic               frame_end;
  } mix_in_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic signed [31:0] out_value;
    logic               last;
  } mix_out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         obj;
    logic [3:0]         channel;
    logic signed [23:0] tgain;
    logic [15:0]        blocks;
    logic [3:0]         std_index;
    logic signed [23:0] sample;
    logic               add_obj;
    logic               add_lfe;
    logic               frame_end;
  } mix_op_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] cur;
    logic signed [GAIN_W-1:0] tgt;
    logic signed [GAIN_W-1:0] step;
    logic [REM_W-1:0]         rem;
  } gain_entry_t;

  localparam int ENTRY_W = $bits(gain_entry_t);

  function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [25:0] v);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (v > hi) return hi[GAIN_W-1:0];
    else if (v < lo) return lo[GAIN_W-1:0];
    else return v[GAIN_W-1:0];
  endfunction

endpackage

FILE: rtl/core/mgm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module mgm_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mgm_div.sv
// iterative restoring divider, one quotient bit per cycle
// uses mgm_pkg
module mgm_div
  import mgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [24:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [24:0] quotient
);

  logic [15:0] rem_r;
  logic [24:0] quo_r;
  logic [15:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem_r, quo_r[24]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd24;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[23:0], 1'b1};
      end else begin
        rem_r <= shifted[15:0];
        quo_r <= {quo_r[23:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/mgm_front.sv
// front end: accepts items, drops no-ops and items with nothing to do, classifies into ops, two-deep queue
// uses mgm_pkg
module mgm_front
  import mgm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  mix_in_t in_data,
  input  logic [4:0] n_chan,
  input  logic    lfe_en,
  output logic    op_valid,
  output mix_op_t op_head,
  input  logic    op_pop
);

  mix_op_t     q_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        keep;
  mix_op_t     op;
  logic [20:0] dur_sum;
  logic        push;

  assign dur_sum = {1'b0, in_data.ramp_duration} + 21'd15;

  always_comb begin
    op.kind      = OP_SAMPLE;
    op.obj       = 4'(in_data.object - 5'd1);
    op.channel   = in_data.channel;
    op.tgain     = in_data.target_gain;
    op.blocks    = dur_sum[20:5];
    op.std_index = in_data.standard_index;
    op.sample    = in_data.sample;
    op.add_obj   = 1'b0;
    op.add_lfe   = 1'b0;
    op.frame_end = in_data.frame_end;
    keep         = 1'b0;
    unique case (in_data.command)
      CMD_SET_GAIN: begin
        op.kind = OP_GAIN;
        keep = (in_data.object != 5'd0) && (in_data.object <= 5'(OBJECTS)) &&
               ({1'b0, in_data.channel} < n_chan);
      end
      CMD_SET_MAP: begin
        op.kind = OP_MAP;
        keep = 1'b1;
      end
      CMD_SAMPLE: begin
        op.add_lfe = (in_data.object == 5'd0) && lfe_en;
        op.add_obj = (in_data.object != 5'd0) && (in_data.object <= 5'(OBJECTS));
        keep = op.add_lfe || op.add_obj || in_data.frame_end;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign op_valid = (cnt_r != 2'd0);
  assign op_head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (op_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, op_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= op;
  end

endmodule

FILE: rtl/core/mgm_back.sv
// back end: gain store, ramp sweep, per-channel mixing, frame emission
// uses mgm_pkg, mgm_ram, mgm_div
module mgm_back
  import mgm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_valid,
  input  mix_op_t  op_head,
  output logic     op_pop,
  input  logic [4:0] n_chan,
  output logic     out_valid,
  input  logic     out_ready,
  output mix_out_t out_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_G_RD = 4'd2;
  localparam logic [3:0] ST_G_WT = 4'd3;
  localparam logic [3:0] ST_G_DV = 4'd4;
  localparam logic [3:0] ST_S_RD = 4'd5;
  localparam logic [3:0] ST_S_WT = 4'd6;
  localparam logic [3:0] ST_S_GN = 4'd7;
  localparam logic [3:0] ST_S_ML = 4'd8;
  localparam logic [3:0] ST_S_AC = 4'd9;
  localparam logic [3:0] ST_L_AC = 4'd10;
  localparam logic [3:0] ST_F_CK = 4'd11;
  localparam logic [3:0] ST_F_EM = 4'd12;
  localparam logic [3:0] ST_F_CL = 4'd13;
  localparam logic [3:0] ST_A_RD = 4'd14;
  localparam logic [3:0] ST_A_WT = 4'd15;

  logic [3:0]               state_r, state_nxt;
  mix_op_t                  op_r;
  logic [3:0]               c_r;
  logic [ENTRY_AW-1:0]      a_r;
  logic [3:0]               dest_r;
  logic signed [GAIN_W-1:0] cur_r;
  logic                     ramp_r;
  logic signed [29:0]       mul_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic                     neg_r;
  logic [SIB_W-1:0]         sib_r;
  logic signed [ACC_W-1:0]  acc_r [OUT_CHANNELS];
  logic [3:0]               map_r [OUT_CHANNELS];
  logic [ENTRIES-1:0]       valid_r;
  logic                     vld_r;
  logic                     out_valid_r;
  mix_out_t                 out_data_r;

  logic [ENTRY_AW-1:0] raddr;
  logic                we;
  logic [ENTRY_AW-1:0] waddr;
  gain_entry_t         wdata;
  gain_entry_t         rdata;
  gain_entry_t         e;

  logic                div_start;
  logic                div_done;
  logic [24:0]         div_q;
  logic signed [24:0]  diff;
  logic [24:0]         mag;
  logic                do_ramp;
  logic signed [25:0]  q_signed;
  logic signed [29:0]  mul_adj;
  logic signed [24:0]  frac;
  logic                last_c;
  logic                out_free;
  logic [3:0]          acc_sel;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W-1:0] acc_add;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [GAIN_W-1:0] adv_cur;
  logic [REM_W-1:0]    adv_rem;

  mgm_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mgm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (op_r.blocks),
    .done     (div_done),
    .quotient (div_q)
  );

  assign e        = vld_r ? rdata : '0;
  assign diff     = 25'(op_r.tgain) - 25'(e.cur);
  assign mag      = diff[24] ? 25'(-diff) : 25'(diff);
  assign do_ramp  = (mag >= 25'(SNAP_UNITS)) && (op_r.blocks != '0);
  assign q_signed = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign mul_adj  = mul_r + (mul_r[29] ? 30'sd31 : 30'sd0);
  assign frac     = 25'(mul_adj >>> 5);
  assign last_c   = ({1'b0, c_r} + 5'd1) == n_chan;
  assign out_free = !out_valid_r || out_ready;
  assign acc_sel  = (state_r == ST_L_AC) ? LFE_CHANNEL : dest_r;
  assign acc_add  = (state_r == ST_L_AC) ? ACC_W'($signed({op_r.sample, 22'd0})) : prod_r;
  assign acc_sum  = {acc_r[acc_sel][ACC_W-1], acc_r[acc_sel]} + {acc_add[ACC_W-1], acc_add};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      acc_new = acc_sum[ACC_W-1:0];
  end

  always_comb begin
    adv_rem = e.rem;
    adv_cur = e.tgt;
    if (e.rem != '0) begin
      adv_rem = e.rem - 16'd1;
      adv_cur = (adv_rem == '0) ? e.tgt : sat_gain(26'(e.cur) + 26'(e.step));
    end
  end

  always_comb begin
    unique case (state_r)
      ST_G_RD: raddr = {op_r.obj, op_r.channel};
      ST_S_RD: raddr = {op_r.obj, c_r};
      default: raddr = a_r;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    waddr     = {op_r.obj, op_r.channel};
    wdata     = '0;
    div_start = 1'b0;
    priority if (state_r == ST_G_WT) begin
      if (do_ramp) begin
        div_start = 1'b1;
      end else begin
        we    = 1'b1;
        wdata = '{cur: op_r.tgain, tgt: op_r.tgain, step: '0, rem: '0};
      end
    end else if (state_r == ST_G_DV) begin
      we    = div_done;
      wdata = '{cur: cur_r, tgt: op_r.tgain, step: sat_gain(q_signed), rem: op_r.blocks};
    end else if (state_r == ST_A_WT) begin
      we    = vld_r;
      waddr = a_r;
      wdata = '{cur: adv_cur, tgt: e.tgt, step: e.step, rem: adv_rem};
    end else begin
      we = 1'b0;
    end
  end

  assign op_pop = (state_r == ST_IDLE) && op_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (op_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        if (op_r.kind == OP_GAIN) state_nxt = ST_G_RD;
        else if (op_r.kind == OP_MAP) state_nxt = ST_IDLE;
        else if (op_r.add_obj && n_chan != '0) state_nxt = ST_S_RD;
        else if (op_r.add_lfe) state_nxt = ST_L_AC;
        else state_nxt = ST_F_CK;
      end
      ST_G_RD: state_nxt = ST_G_WT;
      ST_G_WT: state_nxt = do_ramp ? ST_G_DV : ST_IDLE;
      ST_G_DV: if (div_done) state_nxt = ST_IDLE;
      ST_S_RD: state_nxt = ST_S_WT;
      ST_S_WT: state_nxt = ST_S_GN;
      ST_S_GN: state_nxt = ST_S_ML;
      ST_S_ML: state_nxt = ST_S_AC;
      ST_S_AC: state_nxt = last_c ? ST_F_CK : ST_S_RD;
      ST_L_AC: state_nxt = ST_F_CK;
      ST_F_CK: begin
        if (!op_r.frame_end) state_nxt = ST_IDLE;
        else if (n_chan == '0) state_nxt = ST_F_CL;
        else state_nxt = ST_F_EM;
      end
      ST_F_EM: if (out_free && last_c) state_nxt = ST_F_CL;
      ST_F_CL: state_nxt = (sib_r == '1) ? ST_A_RD : ST_IDLE;
      ST_A_RD: state_nxt = ST_A_WT;
      ST_A_WT: state_nxt = (a_r == '1) ? ST_IDLE : ST_A_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      sib_r       <= '0;
      out_valid_r <= 1'b0;
      c_r         <= '0;
      a_r         <= '0;
      for (int i = 0; i < OUT_CHANNELS; i++) begin
        acc_r[i] <= '0;
        map_r[i] <= 4'(i);
      end
    end else begin
      state_r <= state_nxt;
      if (we) valid_r[waddr] <= 1'b1;
      out_valid_r <= ((state_r == ST_F_EM) && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_DISP: begin
          c_r <= '0;
          if (op_r.kind == OP_MAP) map_r[op_r.channel] <= op_r.std_index;
        end
        ST_S_AC: begin
          acc_r[acc_sel] <= acc_new;
          c_r <= last_c ? 4'd0 : c_r + 4'd1;
        end
        ST_L_AC: acc_r[acc_sel] <= acc_new;
        ST_F_CK: c_r <= '0;
        ST_F_EM: begin
          if (out_free) c_r <= c_r + 4'd1;
        end
        ST_F_CL: begin
          for (int i = 0; i < OUT_CHANNELS; i++) acc_r[i] <= '0;
          sib_r <= sib_r + 5'd1;
          a_r   <= '0;
        end
        ST_A_WT: a_r <= a_r + 8'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vld_r <= valid_r[raddr];
    if (op_pop) op_r <= op_head;
    if (state_r == ST_S_RD) dest_r <= map_r[c_r];
    if (state_r == ST_G_WT) begin
      cur_r <= e.cur;
      neg_r <= diff[24];
    end
    if (state_r == ST_S_WT) begin
      ramp_r <= (e.rem != '0);
      cur_r  <= e.cur;
      gain_r <= e.tgt;
      mul_r  <= e.step * $signed({1'b0, sib_r});
    end
    if (state_r == ST_S_GN && ramp_r) gain_r <= sat_gain(26'(cur_r) + 26'(frac));
    if (state_r == ST_S_ML) prod_r <= op_r.sample * gain_r;
    if (state_r == ST_F_EM && out_free) begin
      out_data_r.out_channel <= c_r;
      out_data_r.out_value   <= 32'($signed(acc_r[c_r][ACC_W-1:22]));
      out_data_r.last        <= last_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/ramped_gain_object_mixer_unit.sv
// top level of the ramped gain object mixer: config registers, front, back
// uses mgm_pkg, mgm_front, mgm_back
//
// channel   signals                      direction
// in        in_valid/in_ready/in_data    item transfer into the front queue
// out       out_valid/out_ready/out_data one channel sum per transfer
// cfg       cfg_we/cfg_index/cfg_wdata   register write, no wait
//
// an object sample item runs each active channel through the shared gain ram loop
// (read, wait, gain, multiply, accumulate); frame end emits one sum per active
// channel; every 32nd frame the ramp sweep walks all 256 gain ram entries
// reset is synchronous and clears control state; the gain ram is tracked by valid bits
// a stalled output only holds the back end; the front queue keeps taking items until its two entries are full
module ramped_gain_object_mixer_unit
  import mgm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mix_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mix_out_t out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  logic [4:0] active_r;
  logic       lfe_r;
  logic [4:0] n_chan;
  logic       op_valid;
  mix_op_t    op_head;
  logic       op_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 5'd16;
      lfe_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: active_r <= cfg_wdata;
        CFG_LFE:    lfe_r    <= cfg_wdata[0];
        default:    lfe_r    <= lfe_r;
      endcase
    end
  end

  assign n_chan = (active_r > 5'(OUT_CHANNELS)) ? 5'(OUT_CHANNELS) : active_r;

  mgm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .n_chan   (n_chan),
    .lfe_en   (lfe_r),
    .op_valid (op_valid),
    .op_head  (op_head),
    .op_pop   (op_pop)
  );

  mgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_head   (op_head),
    .op_pop    (op_pop),
    .n_chan    (n_chan),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
// self-checking testbench for ramped_gain_object_mixer_unit: random and directed
// items with a cycle-free predictor of gains, ramps and channel sums
// depends on mgm_pkg and the mixer rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mgm_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mix_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_ACTIVE;
  logic [4:0] cfg_wdata = '0;

  ramped_gain_object_mixer_unit dut (.*);

  always #5 clk = ~clk;

  mix_in_t pending_items[$];
  mix_out_t expected_sums[$];
  int send_idle = 0;
  int recv_idle = 0;
  logic in_took = 1'b0;
  bit failed = 0;
  int quiet_cycles = 0;

  // mixer state mirror
  logic signed [23:0] gain_now[256];
  logic signed [23:0] gain_goal[256];
  logic signed [23:0] gain_inc[256];
  logic [15:0] blocks_left[256];
  logic signed [47:0] chan_sum[16];
  logic [3:0] std_of[16];
  logic [4:0] frame_in_block;
  logic [4:0] layout_size;
  logic lfe_on;

  function automatic longint clip(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic mirror_reset();
    for (int i = 0; i < 256; i++) begin
      gain_now[i] = '0;
      gain_goal[i] = '0;
      gain_inc[i] = '0;
      blocks_left[i] = '0;
    end
    for (int c = 0; c < 16; c++) begin
      chan_sum[c] = '0;
      std_of[c] = 4'(c);
    end
    frame_in_block = '0;
    layout_size = 5'd16;
    lfe_on = 1'b0;
  endtask

  task automatic mix_item(input mix_in_t it);
    int n;
    int idx;
    longint blocks;
    longint diff;
    longint gain;
    longint smp;
    mix_out_t r;
    n = layout_size > 16 ? 16 : int'(layout_size);
    smp = longint'(it.sample);
    if (it.command == CMD_SET_GAIN) begin
      if (it.object >= 1 && it.object <= OBJECTS && int'(it.channel) < n) begin
        idx = (int'(it.object) - 1) * 16 + int'(it.channel);
        blocks = (longint'(it.ramp_duration) + 15) / 32;
        if (blocks > 65535) blocks = 65535;
        diff = longint'(it.target_gain) - longint'(gain_now[idx]);
        gain_goal[idx] = it.target_gain;
        if ((diff >= SNAP_UNITS || diff <= -SNAP_UNITS) && blocks != 0) begin
          gain_inc[idx] = 24'(clip(diff / blocks, 24));
          blocks_left[idx] = 16'(blocks);
        end else begin
          gain_now[idx] = it.target_gain;
          gain_inc[idx] = '0;
          blocks_left[idx] = '0;
        end
      end
    end else if (it.command == CMD_SET_MAP) begin
      std_of[it.channel] = it.standard_index;
    end else if (it.command == CMD_SAMPLE) begin
      if (it.object == 0) begin
        if (lfe_on)
          chan_sum[LFE_CHANNEL] = 48'(clip(longint'(chan_sum[LFE_CHANNEL]) + smp * 4194304, 48));
      end else if (it.object <= OBJECTS) begin
        for (int c = 0; c < n; c++) begin
          idx = (int'(it.object) - 1) * 16 + c;
          if (blocks_left[idx] != 0)
            gain = clip(longint'(gain_now[idx]) +
                        (longint'(gain_inc[idx]) * longint'(frame_in_block)) / 32, 24);
          else
            gain = longint'(gain_goal[idx]);
          chan_sum[std_of[c]] = 48'(clip(longint'(chan_sum[std_of[c]]) + smp * gain, 48));
        end
      end
      if (it.frame_end) begin
        for (int c = 0; c < n; c++) begin
          r.out_channel = 4'(c);
          r.out_value = 32'(clip(longint'(chan_sum[c]) >>> 22, 32));
          r.last = (c + 1 == n);
          expected_sums.push_back(r);
        end
        for (int c = 0; c < 16; c++) chan_sum[c] = '0;
        if (frame_in_block == 5'd31) begin
          frame_in_block = '0;
          for (int i = 0; i < 256; i++) begin
            if (blocks_left[i] != 0) begin
              gain_now[i] = 24'(clip(longint'(gain_now[i]) + longint'(gain_inc[i]), 24));
              blocks_left[i] = blocks_left[i] - 16'd1;
              if (blocks_left[i] == 0) gain_now[i] = gain_goal[i];
            end else begin
              gain_now[i] = gain_goal[i];
            end
          end
        end else begin
          frame_in_block = frame_in_block + 5'd1;
        end
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(99) >= recv_idle;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    mix_out_t want;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) mix_item(in_data);
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result channel %0d value %0d", out_data.out_channel,
                 out_data.out_value);
          failed = 1;
        end else begin
          want = expected_sums.pop_front();
          if (out_data.out_channel !== want.out_channel) begin
            $error("out_channel expected %0d actual %0d", want.out_channel,
                   out_data.out_channel);
            failed = 1;
          end
          if (out_data.out_value !== want.out_value) begin
            $error("out_value expected %0d actual %0d", want.out_value, out_data.out_value);
            failed = 1;
          end
          if (out_data.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_data.last);
            failed = 1;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic mix_in_t make_item(logic [1:0] cmd, logic [4:0] obj, logic [3:0] ch,
                                        longint tg, longint dur, int si,
                                        longint smp, int fe);
    mix_in_t it;
    it.command = cmd;
    it.object = obj;
    it.channel = ch;
    it.target_gain = 24'(tg);
    it.ramp_duration = 20'(dur);
    it.standard_index = 4'(si);
    it.sample = 24'(smp);
    it.frame_end = 1'(fe);
    return it;
  endfunction

  function automatic mix_in_t random_item();
    mix_in_t it;
    int pick;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(mix_in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 12) begin
      it.command = CMD_SET_GAIN;
      it.object = 5'($urandom_range(16, 0));
      if ($urandom_range(9) == 0) it.object = 5'($urandom_range(31, 17));
      if ($urandom_range(9) != 0) it.ramp_duration = 20'($urandom_range(300));
      if ($urandom_range(3) == 0) it.target_gain = 24'($urandom_range(8000) - 4000);
    end else if (pick < 17) begin
      it.command = CMD_SET_MAP;
    end else if (pick < 95) begin
      it.command = CMD_SAMPLE;
      it.object = 5'($urandom_range(16));
      if ($urandom_range(19) == 0) it.object = 5'($urandom_range(31, 17));
      it.frame_end = ($urandom_range(2) == 0);
    end else begin
      it.command = CMD_NONE;
    end
    return it;
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_ACTIVE) layout_size = val;
    else lfe_on = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [4:0] phase_active[6];
    logic phase_lfe[6];
    phase_active = '{5'd16, 5'd16, 5'd1, 5'd31, 5'd0, 5'd5};
    phase_lfe = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    mirror_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 6; p++) begin
      send_idle = p < 2 ? 30 : (p < 4 ? 68 : 0);
      recv_idle = p < 2 ? 68 : (p < 4 ? 30 : 0);
      if (p > 0) begin
        write_reg(CFG_ACTIVE, phase_active[p]);
        write_reg(CFG_LFE, {4'd0, phase_lfe[p]});
      end
      if (p == 0 || p == 1) begin
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd1, 4'd0, 8388607, 0, 0, 0, 1));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd16, 4'd15, -8388608, 1048575,
                                          15, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd2, 4'd1, 4194304, 16, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd2, 4'd2, 4194304, 17, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd3, 4'd3, 419, 100, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd0, 4'd4, 4194304, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd17, 4'd4, 4194304, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_GAIN, 5'd31, 4'd4, 4194304, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_MAP, 5'd0, 4'd15, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SET_MAP, 5'd0, 4'd0, 0, 0, 15, 0, 1));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd0, 4'd0, 0, 0, 0, -8388608, 0));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd1, 4'd0, 0, 0, 0, 8388607, 0));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd1, 4'd0, 0, 0, 0, 8388607, 0));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd16, 4'd0, 0, 0, 0, -8388608, 1));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd17, 4'd0, 0, 0, 0, 8388607, 0));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd2, 4'd0, 0, 0, 0, -1, 1));
        pending_items.push_back(make_item(CMD_NONE, 5'd1, 4'd0, 0, 0, 0, 5, 1));
        pending_items.push_back(make_item(CMD_SET_MAP, 5'd0, 4'd15, 0, 0, 15, 0, 0));
        pending_items.push_back(make_item(CMD_SET_MAP, 5'd0, 4'd0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_SAMPLE, 5'd0, 4'd0, 0, 0, 0, 8388607, 1));
      end
      for (int k = 0; k < 40; k++) pending_items.push_back(random_item());
      pending_items.push_back(make_item(CMD_SAMPLE, 5'd1, 4'd0, 0, 0, 0, 1000, 1));
      wait_drained();
    end

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
